### rtl/rcp_pkg.sv
// Shared types and constants for the relay control parser and its peer table.
// Used by the top level and by the port checker; depends on nothing else.
`default_nettype none

package rcp_pkg;

   // Opcodes carried in the first byte of a control packet.
   localparam logic [7:0] OP_ANNOUNCE = 8'd2;
   localparam logic [7:0] OP_DEPART   = 8'd3;
   localparam logic [7:0] OP_LINK     = 8'd6;

   // Packet lengths that do not depend on the name field.
   localparam int LEN_DEPART = 5;
   localparam int LEN_LINK   = 7;
   localparam int MAC_BYTES  = 6;

   // Request modes.
   localparam logic [1:0] MODE_STREAM    = 2'd0;
   localparam logic [1:0] MODE_FIND_MAC  = 2'd1;
   localparam logic [1:0] MODE_FIND_ADDR = 2'd2;
   localparam logic [1:0] MODE_RESERVED  = 2'd3;

   typedef enum logic [3:0] {
      EV_BUSY        = 4'd0,
      EV_ADDED       = 4'd1,
      EV_UPDATED     = 4'd2,
      EV_FULL        = 4'd3,
      EV_REMOVED     = 4'd4,
      EV_RETAINED    = 4'd5,
      EV_MISS_REMOVE = 4'd6,
      EV_CONNECTED   = 4'd7,
      EV_BAD         = 4'd8,
      EV_HIT         = 4'd9,
      EV_MISS        = 4'd10
   } event_type;

   typedef enum logic [1:0] {
      LINK_CONNECTING = 2'd0,
      LINK_CONNECTED  = 2'd1,
      LINK_FAILED     = 2'd2
   } link_type;

   typedef enum logic [1:0] {
      OPK_ANNOUNCE,
      OPK_DEPART,
      OPK_LINK
   } op_type;

   typedef enum logic [1:0] {
      JOB_FIND_MAC,
      JOB_FIND_ADDR,
      JOB_ANNOUNCE,
      JOB_DEPART
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESOLVE,
      ST_DEP_RD,
      ST_DEP_WR
   } state_type;

endpackage

`default_nettype wire

### rtl/relay_control_parser_peer_table.sv
// Stream bytes are taken back to back, each result strobed in the cycle after the
// transaction; lookups and the last byte of an announcement or departure instead walk
// the table with one read per cycle until a match or the last entry, then strobe the
// result, and a departure that removes a peer first moves the last entry into place.
// Synchronous reset empties the table (count to zero) and sets the link to connecting.
// Results cannot be held off by the receiver.
`default_nettype none

module relay_control_parser_peer_table
   import rcp_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int NAME_BYTES  = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [47:0] req_key_mac,
   input  wire logic [31:0] req_key_address,
   input  wire logic        req_session_active,
   input  wire logic [31:0] req_session_address,
   output logic             rsp_strobe,
   output logic [3:0]       rsp_event_res,
   output logic [47:0]      rsp_peer_mac,
   output logic [31:0]      rsp_peer_address,
   output logic [4:0]       rsp_peer_count,
   output logic [1:0]       rsp_link_state
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int POS_W = $clog2(NAME_BYTES + 11);

   localparam logic [POS_W-1:0] POS_MAC_LO  = POS_W'(NAME_BYTES);
   localparam logic [POS_W-1:0] POS_MAC_HI  = POS_W'(NAME_BYTES + MAC_BYTES);
   localparam logic [POS_W-1:0] LAST_ANN    = POS_W'(NAME_BYTES + 10);
   localparam logic [POS_W-1:0] LAST_DEPART = POS_W'(LEN_DEPART - 1);
   localparam logic [POS_W-1:0] LAST_LINK   = POS_W'(LEN_LINK - 1);
   localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(MAX_ENTRIES);

   // Table memories and their registered read data.
   logic [47:0] tbl_mac_ff  [MAX_ENTRIES];
   logic [31:0] tbl_addr_ff [MAX_ENTRIES];
   logic [47:0] rd_mac_ff;
   logic [31:0] rd_addr_ff;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;
   logic             wr_mac_en;
   logic             wr_addr_en;
   logic [47:0]      wr_mac;
   logic [31:0]      wr_addr;

   state_type state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   op_type           op_ff, op_in;
   logic [47:0]      mac_acc_ff, mac_acc_in;
   logic [31:0]      addr_acc_ff, addr_acc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   link_type         link_ff, link_in;

   job_type          job_ff, job_in;
   logic [47:0]      key_mac_ff, key_mac_in;
   logic [31:0]      key_addr_ff, key_addr_in;
   logic             sess_act_ff, sess_act_in;
   logic [31:0]      sess_addr_ff, sess_addr_in;

   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [47:0]      hit_mac_ff, hit_mac_in;
   logic [31:0]      hit_addr_ff, hit_addr_in;

   logic             rsp_strobe_ff, rsp_strobe_in;
   event_type        rsp_event_ff, rsp_event_in;
   logic [47:0]      rsp_mac_ff, rsp_mac_in;
   logic [31:0]      rsp_addr_ff, rsp_addr_in;

   logic             accept;
   logic             start_scan;
   logic             match;
   logic             scan_more;
   logic             scan_done;
   logic             retain;
   logic [POS_W-1:0] pos_last;
   logic [47:0]      mac_next;
   logic [31:0]      addr_next;
   logic [CNT_W-1:0] last_cnt;
   logic [CNT_W+4:0] cnt_ext;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign last_cnt = count_ff - CNT_W'(1);
   assign cnt_ext  = {5'd0, count_ff};

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_event_res    = rsp_event_ff;
   assign rsp_peer_mac     = rsp_mac_ff;
   assign rsp_peer_address = rsp_addr_ff;
   assign rsp_peer_count   = cnt_ext[4:0];
   assign rsp_link_state   = link_ff;

   // Field accumulation for the byte at the current position.
   always_comb begin
      mac_next  = mac_acc_ff;
      addr_next = addr_acc_ff;
      pos_last  = LAST_LINK;
      unique case (op_ff)
         OPK_ANNOUNCE: begin
            pos_last = LAST_ANN;
            if (pos_ff > POS_MAC_LO && pos_ff <= POS_MAC_HI) begin
               mac_next = {mac_acc_ff[39:0], req_data_byte};
            end else if (pos_ff > POS_MAC_HI) begin
               addr_next = {addr_acc_ff[23:0], req_data_byte};
            end
         end
         OPK_DEPART: begin
            pos_last  = LAST_DEPART;
            addr_next = {addr_acc_ff[23:0], req_data_byte};
         end
         default: begin
            pos_last = LAST_LINK;
         end
      endcase
   end

   // A lookup, or the last byte of an announcement or departure, starts a table walk.
   always_comb begin
      start_scan = 1'b0;
      if (accept) begin
         if (req_mode == MODE_FIND_MAC || req_mode == MODE_FIND_ADDR) begin
            start_scan = 1'b1;
         end else if (req_mode == MODE_STREAM && link_ff != LINK_FAILED &&
                      pos_ff != '0 && pos_ff == pos_last && op_ff != OPK_LINK) begin
            start_scan = 1'b1;
         end
      end
   end

   // The read data in rd_*_ff belongs to entry chk_idx_ff when chk_valid_ff is set.
   always_comb begin
      if (job_ff == JOB_FIND_MAC) begin
         match = chk_valid_ff && (rd_mac_ff == key_mac_ff);
      end else begin
         match = chk_valid_ff && (rd_addr_ff == key_addr_ff);
      end
      scan_more = (scan_ff < count_ff);
      scan_done = match || (!scan_more && !chk_valid_ff);
      retain    = sess_act_ff && (sess_addr_ff == key_addr_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_scan) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (job_ff == JOB_DEPART && hit_ff && !retain) begin
               state_in = ST_DEP_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DEP_RD: begin
            state_in = ST_DEP_WR;
         end
         ST_DEP_WR: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      pos_in        = pos_ff;
      op_in         = op_ff;
      mac_acc_in    = mac_acc_ff;
      addr_acc_in   = addr_acc_ff;
      count_in      = count_ff;
      link_in       = link_ff;
      job_in        = job_ff;
      key_mac_in    = key_mac_ff;
      key_addr_in   = key_addr_ff;
      sess_act_in   = sess_act_ff;
      sess_addr_in  = sess_addr_ff;
      scan_in       = scan_ff;
      chk_valid_in  = chk_valid_ff;
      chk_idx_in    = chk_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_mac_in    = hit_mac_ff;
      hit_addr_in   = hit_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_event_in  = rsp_event_ff;
      rsp_mac_in    = rsp_mac_ff;
      rsp_addr_in   = rsp_addr_ff;
      rd_idx        = scan_ff[IDX_W-1:0];
      wr_idx        = hit_idx_ff;
      wr_mac_en     = 1'b0;
      wr_addr_en    = 1'b0;
      wr_mac        = mac_acc_ff;
      wr_addr       = key_addr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_mac_in   = req_key_mac;
               key_addr_in  = req_key_address;
               sess_act_in  = req_session_active;
               sess_addr_in = req_session_address;
               scan_in      = '0;
               chk_valid_in = 1'b0;
               hit_in       = 1'b0;
               rsp_event_in = EV_BUSY;
               rsp_mac_in   = '0;
               rsp_addr_in  = '0;
               unique case (req_mode)
                  MODE_STREAM: begin
                     if (link_ff == LINK_FAILED) begin
                        rsp_strobe_in = 1'b1;
                     end else if (pos_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        mac_acc_in    = '0;
                        addr_acc_in   = '0;
                        if (req_data_byte == OP_ANNOUNCE) begin
                           op_in  = OPK_ANNOUNCE;
                           pos_in = POS_W'(1);
                        end else if (req_data_byte == OP_DEPART) begin
                           op_in  = OPK_DEPART;
                           pos_in = POS_W'(1);
                        end else if (req_data_byte == OP_LINK) begin
                           op_in  = OPK_LINK;
                           pos_in = POS_W'(1);
                        end else begin
                           // Unknown opcode: the link is lost and the table emptied.
                           link_in      = LINK_FAILED;
                           count_in     = '0;
                           rsp_event_in = EV_BAD;
                        end
                     end else begin
                        mac_acc_in  = mac_next;
                        addr_acc_in = addr_next;
                        if (pos_ff != pos_last) begin
                           pos_in        = pos_ff + POS_W'(1);
                           rsp_strobe_in = 1'b1;
                        end else begin
                           pos_in      = '0;
                           key_addr_in = addr_next;
                           unique case (op_ff)
                              OPK_ANNOUNCE: job_in = JOB_ANNOUNCE;
                              OPK_DEPART:   job_in = JOB_DEPART;
                              default: begin
                                 link_in       = LINK_CONNECTED;
                                 rsp_event_in  = EV_CONNECTED;
                                 rsp_strobe_in = 1'b1;
                              end
                           endcase
                        end
                     end
                  end
                  MODE_FIND_MAC:  job_in = JOB_FIND_MAC;
                  MODE_FIND_ADDR: job_in = JOB_FIND_ADDR;
                  default:        rsp_strobe_in = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            if (match) begin
               hit_in       = 1'b1;
               hit_idx_in   = chk_idx_ff;
               hit_mac_in   = rd_mac_ff;
               hit_addr_in  = rd_addr_ff;
               chk_valid_in = 1'b0;
            end else if (scan_more) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = scan_ff[IDX_W-1:0];
               scan_in      = scan_ff + CNT_W'(1);
            end else begin
               chk_valid_in = 1'b0;
            end
         end
         ST_RESOLVE: begin
            unique case (job_ff)
               JOB_ANNOUNCE: begin
                  rsp_strobe_in = 1'b1;
                  rsp_mac_in    = mac_acc_ff;
                  rsp_addr_in   = key_addr_ff;
                  if (hit_ff) begin
                     wr_mac_en    = 1'b1;
                     rsp_event_in = EV_UPDATED;
                  end else if (count_ff >= CNT_MAX) begin
                     rsp_event_in = EV_FULL;
                  end else begin
                     wr_idx       = count_ff[IDX_W-1:0];
                     wr_mac_en    = 1'b1;
                     wr_addr_en   = 1'b1;
                     count_in     = count_ff + CNT_W'(1);
                     rsp_event_in = EV_ADDED;
                  end
               end
               JOB_DEPART: begin
                  if (!hit_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_event_in  = EV_MISS_REMOVE;
                     rsp_mac_in    = '0;
                     rsp_addr_in   = key_addr_ff;
                  end else if (retain) begin
                     // The active protected session peer stays in the table.
                     rsp_strobe_in = 1'b1;
                     rsp_event_in  = EV_RETAINED;
                     rsp_mac_in    = hit_mac_ff;
                     rsp_addr_in   = hit_addr_ff;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  if (hit_ff) begin
                     rsp_event_in = EV_HIT;
                     rsp_mac_in   = hit_mac_ff;
                     rsp_addr_in  = hit_addr_ff;
                  end else begin
                     rsp_event_in = EV_MISS;
                     rsp_mac_in   = '0;
                     rsp_addr_in  = '0;
                  end
               end
            endcase
         end
         ST_DEP_RD: begin
            rd_idx = last_cnt[IDX_W-1:0];
         end
         ST_DEP_WR: begin
            // The last entry, read in the previous cycle, fills the vacated slot.
            wr_mac_en     = 1'b1;
            wr_addr_en    = 1'b1;
            wr_mac        = rd_mac_ff;
            wr_addr       = rd_addr_ff;
            count_in      = last_cnt;
            rsp_strobe_in = 1'b1;
            rsp_event_in  = EV_REMOVED;
            rsp_mac_in    = hit_mac_ff;
            rsp_addr_in   = hit_addr_ff;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_mac_en) begin
         tbl_mac_ff[wr_idx] <= wr_mac;
      end
      if (wr_addr_en) begin
         tbl_addr_ff[wr_idx] <= wr_addr;
      end
      rd_mac_ff  <= tbl_mac_ff[rd_idx];
      rd_addr_ff <= tbl_addr_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         op_ff         <= OPK_LINK;
         mac_acc_ff    <= '0;
         addr_acc_ff   <= '0;
         count_ff      <= '0;
         link_ff       <= LINK_CONNECTING;
         chk_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         op_ff         <= op_in;
         mac_acc_ff    <= mac_acc_in;
         addr_acc_ff   <= addr_acc_in;
         count_ff      <= count_in;
         link_ff       <= link_in;
         chk_valid_ff  <= chk_valid_in;
         hit_ff        <= hit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      key_mac_ff   <= key_mac_in;
      key_addr_ff  <= key_addr_in;
      sess_act_ff  <= sess_act_in;
      sess_addr_ff <= sess_addr_in;
      scan_ff      <= scan_in;
      chk_idx_ff   <= chk_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_mac_ff   <= hit_mac_in;
      hit_addr_ff  <= hit_addr_in;
      rsp_event_ff <= rsp_event_in;
      rsp_mac_ff   <= rsp_mac_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

endmodule

`default_nettype wire

### rtl/rcp_checker.sv
// Port-level checks for the relay control parser, attached by the bind below.
// Depends on rcp_pkg for the link state codes.
`default_nettype none

module rcp_checker
   import rcp_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic [4:0] rsp_peer_count,
   input wire logic [1:0] rsp_link_state
);

   // A result is only presented once the block is free for the next transaction.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // Every accepted transaction either answers at once or starts a table walk.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted transaction made no progress");

   // A failed link stays failed until reset.
   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_link_state == LINK_FAILED) |=> (rsp_link_state == LINK_FAILED))
      else $error("link left the failed state");

   // The table is empty whenever the link has failed.
   a_failed_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_link_state == LINK_FAILED) |-> (rsp_peer_count == 5'd0))
      else $error("table not empty after link failure");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(rsp_peer_count) <= MAX_ENTRIES))
      else $error("peer count above table capacity");

endmodule

bind relay_control_parser_peer_table rcp_checker #(
   .MAX_ENTRIES(MAX_ENTRIES)
) u_rcp_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_peer_count (rsp_peer_count),
   .rsp_link_state (rsp_link_state)
);

`default_nettype wire

### sim/tb_relay_control_parser_peer_table.sv
// Self-checking bench for relay_control_parser_peer_table: framing, peer table and lookups.
// Needs rcp_pkg and the top level only. Results are predicted per transaction and
// checked field by field as they come out.
`timescale 1ns / 1ps

module tb_relay_control_parser_peer_table;
   import rcp_pkg::*;

   localparam int MAX_ENTRIES   = 16;
   localparam int NAME_BYTES    = 128;
   localparam int ANNOUNCE_LEN  = 1 + NAME_BYTES + MAC_BYTES + 4;
   localparam int ITEM_TARGET   = 850;
   localparam int TAIL_ITEMS    = 15;
   localparam int POOL_SIZE     = 24;
   localparam int GAP_MAX       = 10;
   localparam int PRINT_CAP     = 50;

   typedef struct {
      logic [1:0]  mode;
      logic [7:0]  data_byte;
      logic [47:0] key_mac;
      logic [31:0] key_address;
      logic        session_active;
      logic [31:0] session_address;
   } request_type;

   typedef struct {
      event_type   ev;
      logic [47:0] mac;
      logic [31:0] addr;
      logic [4:0]  count;
      link_type    link;
   } peer_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = MODE_STREAM;
   logic [7:0]  req_data_byte = '0;
   logic [47:0] req_key_mac = '0;
   logic [31:0] req_key_address = '0;
   logic        req_session_active = 1'b0;
   logic [31:0] req_session_address = '0;
   logic        rsp_strobe;
   logic [3:0]  rsp_event_res;
   logic [47:0] rsp_peer_mac;
   logic [31:0] rsp_peer_address;
   logic [4:0]  rsp_peer_count;
   logic [1:0]  rsp_link_state;

   relay_control_parser_peer_table #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .NAME_BYTES (NAME_BYTES)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_key_mac        (req_key_mac),
      .req_key_address    (req_key_address),
      .req_session_active (req_session_active),
      .req_session_address(req_session_address),
      .rsp_strobe         (rsp_strobe),
      .rsp_event_res      (rsp_event_res),
      .rsp_peer_mac       (rsp_peer_mac),
      .rsp_peer_address   (rsp_peer_address),
      .rsp_peer_count     (rsp_peer_count),
      .rsp_link_state     (rsp_link_state)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   request_type    pending_requests[$];
   peer_event_type expected_events[$];
   request_type    current_req;

   int error_count = 0;
   int accepted_items = 0;
   int checked_results = 0;
   int total_items = 0;
   int counted_items = 0;
   int interleave_pct = 0;
   int cycle_count = 0;
   int cycle_limit = 1000000;
   int burst_left = 1;
   int gap_left = 0;
   int ev_tally[16];

   // Shadow of the parser and the peer table.
   int unsigned frame_pos = 0;
   logic [7:0]  frame_op = '0;
   logic [47:0] mac_shift = '0;
   logic [31:0] addr_shift = '0;
   logic [47:0] tbl_mac [MAX_ENTRIES];
   logic [31:0] tbl_addr [MAX_ENTRIES];
   int unsigned peer_total = 0;
   link_type    link_now = LINK_CONNECTING;

   logic [31:0] addr_pool [POOL_SIZE];
   logic [47:0] mac_pool[$];

   function automatic int locate(input logic by_mac, input logic [47:0] m,
                                 input logic [31:0] a);
      for (int i = 0; i < int'(peer_total); i++) begin
         if (by_mac ? (tbl_mac[i] == m) : (tbl_addr[i] == a)) return i;
      end
      return -1;
   endfunction

   task automatic predict_peer_event(input request_type it);
      peer_event_type r;
      int             idx;
      int unsigned    frame_len;
      r.ev   = EV_BUSY;
      r.mac  = '0;
      r.addr = '0;
      if (it.mode == MODE_STREAM && link_now != LINK_FAILED) begin
         if (frame_pos == 0) begin
            if (it.data_byte != OP_ANNOUNCE && it.data_byte != OP_DEPART &&
                it.data_byte != OP_LINK) begin
               // An unknown opcode kills the link for good and empties the table.
               link_now   = LINK_FAILED;
               peer_total = 0;
               frame_op   = '0;
               mac_shift  = '0;
               addr_shift = '0;
               r.ev       = EV_BAD;
            end else begin
               frame_op   = it.data_byte;
               frame_pos  = 1;
               mac_shift  = '0;
               addr_shift = '0;
            end
         end else begin
            if (frame_op == OP_ANNOUNCE) begin
               if (frame_pos > NAME_BYTES && frame_pos <= NAME_BYTES + MAC_BYTES)
                  mac_shift = {mac_shift[39:0], it.data_byte};
               else if (frame_pos > NAME_BYTES + MAC_BYTES)
                  addr_shift = {addr_shift[23:0], it.data_byte};
            end else if (frame_op == OP_DEPART) begin
               addr_shift = {addr_shift[23:0], it.data_byte};
            end
            frame_len = (frame_op == OP_ANNOUNCE) ? ANNOUNCE_LEN :
                        (frame_op == OP_DEPART) ? LEN_DEPART : LEN_LINK;
            if (frame_pos + 1 < frame_len) begin
               frame_pos++;
            end else begin
               frame_pos = 0;
               idx = locate(1'b0, '0, addr_shift);
               if (frame_op == OP_ANNOUNCE) begin
                  r.mac  = mac_shift;
                  r.addr = addr_shift;
                  if (idx >= 0) begin
                     tbl_mac[idx] = mac_shift;
                     r.ev = EV_UPDATED;
                  end else if (peer_total >= MAX_ENTRIES) begin
                     r.ev = EV_FULL;
                  end else begin
                     tbl_mac[peer_total]  = mac_shift;
                     tbl_addr[peer_total] = addr_shift;
                     peer_total++;
                     r.ev = EV_ADDED;
                  end
               end else if (frame_op == OP_DEPART) begin
                  if (idx < 0) begin
                     r.addr = addr_shift;
                     r.ev   = EV_MISS_REMOVE;
                  end else begin
                     r.mac  = tbl_mac[idx];
                     r.addr = tbl_addr[idx];
                     if (it.session_active && it.session_address == addr_shift) begin
                        r.ev = EV_RETAINED;
                     end else begin
                        // The last entry fills the hole.
                        tbl_mac[idx]  = tbl_mac[peer_total - 1];
                        tbl_addr[idx] = tbl_addr[peer_total - 1];
                        peer_total--;
                        r.ev = EV_REMOVED;
                     end
                  end
               end else begin
                  link_now = LINK_CONNECTED;
                  r.ev     = EV_CONNECTED;
               end
            end
         end
      end else if (it.mode == MODE_FIND_MAC || it.mode == MODE_FIND_ADDR) begin
         idx = locate(it.mode == MODE_FIND_MAC, it.key_mac, it.key_address);
         if (idx >= 0) begin
            r.ev   = EV_HIT;
            r.mac  = tbl_mac[idx];
            r.addr = tbl_addr[idx];
         end else begin
            r.ev = EV_MISS;
         end
      end
      r.count = 5'(peer_total);
      r.link  = link_now;
      expected_events.push_back(r);
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      if (error_count < PRINT_CAP)
         $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   // ---- Stimulus construction ----

   function automatic request_type random_req(input logic [1:0] mode);
      request_type r;
      r.mode            = mode;
      r.data_byte       = 8'($urandom);
      r.key_mac         = 48'({$urandom, $urandom});
      r.key_address     = $urandom;
      r.session_active  = 1'($urandom);
      r.session_address = $urandom;
      return r;
   endfunction

   task automatic send_lookup(input logic [1:0] mode, input logic [47:0] m,
                              input logic [31:0] a);
      request_type r;
      r = random_req(mode);
      r.key_mac     = m;
      r.key_address = a;
      if (mode != MODE_RESERVED) counted_items++;
      pending_requests.push_back(r);
   endtask

   // Lookups and the unused mode, dropped into the middle of packets or sent on their own.
   task automatic send_noise();
      logic [1:0] m;
      m = 2'($urandom_range(3, 1));
      send_lookup(m, ($urandom_range(1) && mac_pool.size() != 0) ?
                  mac_pool[$urandom_range(mac_pool.size() - 1)] : 48'({$urandom, $urandom}),
                  $urandom_range(1) ? addr_pool[$urandom_range(POOL_SIZE - 1)] : $urandom);
   endtask

   task automatic send_byte(input logic [7:0] b, input bit counts, input bit sact,
                            input logic [31:0] saddr, input bit fix_session);
      request_type r;
      if (interleave_pct != 0 && $urandom_range(99) < interleave_pct) send_noise();
      r = random_req(MODE_STREAM);
      r.data_byte = b;
      if (fix_session) begin
         r.session_active  = sact;
         r.session_address = saddr;
      end
      if (counts) counted_items++;
      pending_requests.push_back(r);
   endtask

   task automatic send_announce(input logic [47:0] m, input logic [31:0] a);
      send_byte(OP_ANNOUNCE, 1, 0, '0, 0);
      for (int i = 0; i < NAME_BYTES; i++) send_byte(8'($urandom), 0, 0, '0, 0);
      for (int i = MAC_BYTES - 1; i >= 0; i--) send_byte(m[8*i +: 8], 1, 0, '0, 0);
      for (int i = 3; i >= 0; i--) send_byte(a[8*i +: 8], 1, 0, '0, 0);
      mac_pool.push_back(m);
      if (mac_pool.size() > 32) void'(mac_pool.pop_front());
   endtask

   task automatic send_depart(input logic [31:0] a, input bit sact, input logic [31:0] saddr);
      send_byte(OP_DEPART, 1, 0, '0, 0);
      for (int i = 3; i >= 0; i--) send_byte(a[8*i +: 8], 1, sact, saddr, i == 0);
   endtask

   task automatic send_link();
      send_byte(OP_LINK, 1, 0, '0, 0);
      for (int i = 0; i < LEN_LINK - 1; i++) send_byte(8'($urandom), 1, 0, '0, 0);
   endtask

   // ---- Driver ----

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_peer_event(current_req);
            accepted_items++;
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               current_req = pending_requests.pop_front();
               req_mode            <= current_req.mode;
               req_data_byte       <= current_req.data_byte;
               req_key_mac         <= current_req.key_mac;
               req_key_address     <= current_req.key_address;
               req_session_active  <= current_req.session_active;
               req_session_address <= current_req.session_address;
               start <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(20, 1);
                  gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(GAP_MAX, 1);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---- Monitor ----

   always @(posedge clock) begin
      peer_event_type want;
      if (!reset && rsp_strobe) begin
         ev_tally[rsp_event_res]++;
         if (expected_events.size() == 0) begin
            report("unexpected result event", 64'(rsp_event_res), '0);
         end else begin
            want = expected_events.pop_front();
            checked_results++;
            if (rsp_event_res !== want.ev) report("event", 64'(rsp_event_res), 64'(want.ev));
            if (rsp_peer_mac !== want.mac) report("peer_mac", 64'(rsp_peer_mac), 64'(want.mac));
            if (rsp_peer_address !== want.addr)
               report("peer_address", 64'(rsp_peer_address), 64'(want.addr));
            if (rsp_peer_count !== want.count)
               report("peer_count", 64'(rsp_peer_count), 64'(want.count));
            if (rsp_link_state !== want.link)
               report("link_state", 64'(rsp_link_state), 64'(want.link));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, expected_events.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [31:0] a;
      logic [31:0] saddr;
      logic [47:0] m;
      logic [7:0]  bad_op;
      bit          fill_phase;
      int          op_no;
      int          pick;

      for (int i = 0; i < 16; i++) ev_tally[i] = 0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         tbl_mac[i]  = '0;
         tbl_addr[i] = '0;
      end
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

      // Directed: empty-table lookups, the unused mode, a departure nobody matches,
      // the link notice, add/update at the address extremes, a lookup in mid-packet,
      // then a protected departure followed by a real one.
      send_lookup(MODE_FIND_MAC, '0, '0);
      send_lookup(MODE_FIND_ADDR, '1, '1);
      send_lookup(MODE_RESERVED, '1, '1);
      send_depart('1, 1'b1, '1);
      send_link();
      send_announce('1, '0);
      send_byte(OP_ANNOUNCE, 1, 0, '0, 0);
      for (int i = 0; i < NAME_BYTES; i++) send_byte(8'($urandom), 0, 0, '0, 0);
      send_lookup(MODE_FIND_MAC, '1, '0);
      send_lookup(MODE_RESERVED, '0, '0);
      for (int i = 0; i < MAC_BYTES; i++) send_byte('0, 1, 0, '0, 0);
      for (int i = 0; i < 4; i++) send_byte(8'hFF, 1, 0, '0, 0);
      mac_pool.push_back('0);
      send_announce(48'h1234_5678_9ABC, '1);
      send_lookup(MODE_FIND_ADDR, '0, '1);
      send_lookup(MODE_FIND_MAC, '0, '0);
      send_depart('0, 1'b1, '0);
      send_depart('0, 1'b0, '0);
      send_lookup(MODE_FIND_ADDR, '0, '1);

      // Random: short phases that lean toward adding peers alternate with phases
      // that lean toward removing them. An announcement is only sent while it
      // still fits in the item budget.
      interleave_pct = 3;
      fill_phase = 1'b0;
      op_no = 0;
      while (pending_requests.size() + TAIL_ITEMS < ITEM_TARGET) begin
         if (op_no % 10 == 0) fill_phase = !fill_phase;
         op_no++;
         pick = $urandom_range(99);
         a = addr_pool[$urandom_range(POOL_SIZE - 1)];
         if (pick < (fill_phase ? 20 : 6) &&
             pending_requests.size() + ANNOUNCE_LEN + TAIL_ITEMS < ITEM_TARGET) begin
            case ($urandom_range(7))
               0:       m = '0;
               1:       m = '1;
               default: m = 48'({$urandom, $urandom});
            endcase
            send_announce(m, a);
         end else if (pick < 60) begin
            saddr = $urandom_range(1) ? a : addr_pool[$urandom_range(POOL_SIZE - 1)];
            send_depart(a, 1'($urandom), saddr);
         end else if (pick < 68) begin
            send_link();
         end else begin
            send_noise();
         end
      end

      // Failure: an unknown opcode, then bytes that must be ignored and lookups
      // against the emptied table.
      interleave_pct = 0;
      do bad_op = 8'($urandom);
      while (bad_op == OP_ANNOUNCE || bad_op == OP_DEPART || bad_op == OP_LINK);
      send_byte(bad_op, 1, 0, '0, 0);
      send_byte(OP_ANNOUNCE, 0, 0, '0, 0);
      send_byte(OP_LINK, 0, 0, '0, 0);
      for (int i = 0; i < 6; i++) begin
         send_byte(8'($urandom), 0, 0, '0, 0);
         send_noise();
      end

      total_items = pending_requests.size();
      cycle_limit = total_items * (MAX_ENTRIES + 8 + GAP_MAX) * 4 + 10000;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (accepted_items < total_items || expected_events.size() != 0) @(posedge clock);
      repeat (MAX_ENTRIES + 8) @(posedge clock);

      $display("Drove %0d transactions (%0d outside peer names) and checked %0d results in %0d cycles.",
               accepted_items, counted_items, checked_results, cycle_count);
      $display("Seen: %0d added, %0d updated, %0d dropped on full table, %0d removed, %0d kept.",
               ev_tally[EV_ADDED], ev_tally[EV_UPDATED], ev_tally[EV_FULL],
               ev_tally[EV_REMOVED], ev_tally[EV_RETAINED]);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
